// File: rtl/core/deq_pkg.sv
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // pos < DEPTH and off <= DEPTH, so one subtract wraps the sum
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] pos,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(pos) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

endpackage

// File: rtl/core/deq_ram.sv
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit items held in a ring RAM of
// deq_pkg::DEPTH entries. Drive start high with an operation while busy is
// low; the item is taken at that clock edge. Push and pop give one result
// on the cycle after acceptance, and the next item may be taken in that
// same cycle, so a stream of pushes and pops runs at one item per clock.
// A dump holds busy high while it reads the stored items, one RAM read per
// cycle, and presents them front to back on consecutive cycles, each from
// the registered RAM read data; the final one comes out in the
// cycle in which busy is low again, and last marks it. Dumping an empty
// queue gives one result with status empty on the cycle after acceptance.
// Operation codes 5 to 7 are taken and dropped with no result. Every
// result is on the outputs for exactly one cycle, marked by done; the
// receiver cannot stall the block, so it must take each result in the
// cycle it appears.
module double_ended_queue (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic        [deq_pkg::OP_W-1:0]         operation,
  input  logic signed [deq_pkg::DATA_W-1:0]       value,
  output logic                                    busy,
  output logic                                    done,
  output logic        [deq_pkg::ST_W-1:0]         status,
  output logic signed [deq_pkg::DATA_W-1:0]       element,
  output logic                                    last
);

  typedef enum logic {IDLE, DUMP} state_t;

  state_t                        state;
  logic [deq_pkg::IW-1:0]        front;
  logic [deq_pkg::CW-1:0]        count;
  logic [deq_pkg::IW-1:0]        rd_addr;
  logic [deq_pkg::CW-1:0]        rd_left;
  logic                          el_sel;

  logic                          full;
  logic                          empty;
  logic [deq_pkg::IW-1:0]        front_dec;
  logic                          wr_en;
  logic [deq_pkg::IW-1:0]        wr_addr;
  logic                          rd_en;
  logic [deq_pkg::DATA_W-1:0]    rd_data;

  assign busy      = (state == DUMP);
  assign full      = (count == deq_pkg::CW'(deq_pkg::DEPTH));
  assign empty     = (count == '0);
  assign front_dec = deq_pkg::ring_add(front, deq_pkg::CW'(deq_pkg::DEPTH - 1));
  assign wr_en     = (state == IDLE) && start && !full &&
                     ((operation == deq_pkg::OP_PUSH_FRONT) ||
                      (operation == deq_pkg::OP_PUSH_BACK));
  assign wr_addr   = (operation == deq_pkg::OP_PUSH_FRONT) ? front_dec
                                                           : deq_pkg::ring_add(front, count);
  assign rd_en     = (state == DUMP);
  assign element   = el_sel ? $signed(rd_data) : '0;

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      front   <= '0;
      count   <= '0;
      rd_addr <= '0;
      rd_left <= '0;
      done    <= 1'b0;
      el_sel  <= 1'b0;
      status  <= deq_pkg::ST_OK;
      last    <= 1'b0;
    end else begin
      done   <= 1'b0;
      el_sel <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            case (operation) inside
              deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                done <= 1'b1;
                last <= 1'b1;
                if (full) begin
                  status <= deq_pkg::ST_FULL;
                end else begin
                  status <= deq_pkg::ST_OK;
                  count  <= count + 1'b1;
                  if (operation == deq_pkg::OP_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                done <= 1'b1;
                last <= 1'b1;
                if (empty) begin
                  status <= deq_pkg::ST_EMPTY;
                end else begin
                  status <= deq_pkg::ST_OK;
                  count  <= count - 1'b1;
                  if (operation == deq_pkg::OP_POP_FRONT) begin
                    front <= deq_pkg::ring_add(front, deq_pkg::CW'(1));
                  end
                end
              end
              deq_pkg::OP_DUMP: begin
                if (empty) begin
                  done   <= 1'b1;
                  last   <= 1'b1;
                  status <= deq_pkg::ST_EMPTY;
                end else begin
                  state   <= DUMP;
                  rd_addr <= front;
                  rd_left <= count;
                end
              end
              default: begin
              end
            endcase
          end
        end
        DUMP: begin
          done    <= 1'b1;
          el_sel  <= 1'b1;
          status  <= deq_pkg::ST_OK;
          last    <= (rd_left == deq_pkg::CW'(1));
          rd_addr <= deq_pkg::ring_add(rd_addr, deq_pkg::CW'(1));
          rd_left <= rd_left - 1'b1;
          if (rd_left == deq_pkg::CW'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/deq_chk.sv
module deq_chk (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    start,
  input logic        [deq_pkg::OP_W-1:0]         operation,
  input logic signed [deq_pkg::DATA_W-1:0]       value,
  input logic                                    busy,
  input logic                                    done,
  input logic        [deq_pkg::ST_W-1:0]         status,
  input logic signed [deq_pkg::DATA_W-1:0]       element,
  input logic                                    last
);

  logic accept_single;
  logic accept_dump;

  assign accept_single = start && !busy &&
                         ((operation == deq_pkg::OP_PUSH_FRONT) ||
                          (operation == deq_pkg::OP_PUSH_BACK)  ||
                          (operation == deq_pkg::OP_POP_FRONT)  ||
                          (operation == deq_pkg::OP_POP_BACK));
  assign accept_dump   = start && !busy && (operation == deq_pkg::OP_DUMP);

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    accept_single |=> done && last && (element == '0))
    else $error("push or pop item gave no single final result");

  a_dump_result: assert property (@(posedge clk) disable iff (rst)
    accept_dump |=> done || busy)
    else $error("dump item neither gave a result nor started a walk");

  a_busy_emits: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && (status == deq_pkg::ST_OK))
    else $error("dump walk cycle did not emit an item");

  a_error_final: assert property (@(posedge clk) disable iff (rst)
    done && (status != deq_pkg::ST_OK) |-> last && (element == '0))
    else $error("empty or full result not final or carries data");

  a_busy_ends: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done && last)
    else $error("dump walk ended without marking the final item");

endmodule

bind double_ended_queue deq_chk u_deq_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .operation (operation),
  .value     (value),
  .busy      (busy),
  .done      (done),
  .status    (status),
  .element   (element),
  .last      (last)
);
